FILE: sv/http_url_splitter_macros.svh
// Assertion macros used by the URL splitter back end.
// Depends on nothing; included by the files that carry assertions.
`ifndef HTTP_URL_SPLITTER_MACROS_SVH
`define HTTP_URL_SPLITTER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define URLSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define URLSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/urlsp_pkg.sv
// Types, codes and constants of the URL splitter.
// Used by the register interface and by every module of the block.
package urlsp_pkg;

   localparam int HOST_CAP_W = 9;
   localparam int PATH_CAP_W = 11;
   localparam logic [HOST_CAP_W-1:0] HOST_CAP_RESET = 9'd256;
   localparam logic [PATH_CAP_W-1:0] PATH_CAP_RESET = 11'd1024;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST_CAP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATH_CAP = 2'd1;

   localparam logic [1:0] KIND_HOST = 2'd0;
   localparam logic [1:0] KIND_PATH = 2'd1;
   localparam logic [1:0] KIND_FINAL = 2'd2;

   localparam logic [1:0] OUTCOME_OK = 2'd0;
   localparam logic [1:0] OUTCOME_TLS = 2'd1;
   localparam logic [1:0] OUTCOME_MALFORMED = 2'd2;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [15:0] PORT_DEFAULT = 16'd80;
   localparam logic [15:0] PORT_MAX = 16'hFFFF;

   // Held-byte counts at which the next byte completes each scheme prefix.
   localparam logic [2:0] PLAIN_HELD_LAST = 3'd6;
   localparam logic [2:0] TLS_HELD_LAST = 3'd7;

   typedef enum logic [1:0] {
      CMD_FEED,
      CMD_END,
      CMD_REFUSE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_byte;
   } cmd_type;

   typedef enum logic [1:0] {
      FRONT_PREFIX,
      FRONT_REPLAY,
      FRONT_PASS
   } front_mode_type;

   typedef enum logic [1:0] {
      PHASE_HOST,
      PHASE_PORT,
      PHASE_PATH,
      PHASE_DRAIN
   } phase_type;

   function automatic logic [7:0] plain_char(logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h68;
         3'd1: ch = 8'h74;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h70;
         3'd4: ch = CHAR_COLON;
         3'd5: ch = CHAR_SLASH;
         3'd6: ch = CHAR_SLASH;
         default: ch = 8'h68;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] tls_char(logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h68;
         3'd1: ch = 8'h74;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h70;
         3'd4: ch = 8'h73;
         3'd5: ch = CHAR_COLON;
         3'd6: ch = CHAR_SLASH;
         3'd7: ch = CHAR_SLASH;
         default: ch = 8'h68;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/urlsp_if.sv
// Channel interfaces of the URL splitter: request, response and register write.
// Depends on urlsp_pkg for the register port widths.
interface urlsp_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_mark;
   modport source (output valid, char_byte, end_mark, input ready);
   modport sink (input valid, char_byte, end_mark, output ready);
endinterface

interface urlsp_rsp_if ();
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [7:0]  value;
   logic [1:0]  outcome;
   logic [15:0] port_number;
   logic        last;
   modport source (output valid, item_kind, value, outcome, port_number, last, input ready);
   modport sink (input valid, item_kind, value, outcome, port_number, last, output ready);
endinterface

interface urlsp_csr_if import urlsp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/urlsp_fifo.sv
// Command queue between the prefix front end and the splitting back end.
// Depends on urlsp_pkg for the command type.
module urlsp_fifo import urlsp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   cmd_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full = (fill_ff == FILL_W'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/urlsp_front.sv
// Front end: accepts characters, strips or refuses the scheme prefix, replays it on a miss.
// Depends on urlsp_pkg and the request interface; feeds commands into urlsp_fifo.
module urlsp_front import urlsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   urlsp_req_if.sink req,
   output logic    push_valid,
   output cmd_type push_cmd,
   input  logic    queue_full
);

   front_mode_type mode_ff, mode_in;
   logic [2:0]     count_ff, count_in;
   logic [2:0]     idx_ff, idx_in;
   logic           plain_ff, plain_in;
   logic           tls_ff, tls_in;
   logic [7:0]     pend_byte_ff, pend_byte_in;
   logic           pend_end_ff, pend_end_in;

   logic       accept;
   logic       plain_hit, tls_hit;
   logic       tls_done, plain_done, hold, mismatch;
   logic       replay_last;
   logic [7:0] held_char;

   assign req.ready = (mode_ff != FRONT_REPLAY) && !queue_full;
   assign accept = req.valid && req.ready;

   assign plain_hit = plain_ff && (count_ff != TLS_HELD_LAST) &&
                      (req.char_byte == plain_char(count_ff));
   assign tls_hit = tls_ff && (req.char_byte == tls_char(count_ff));
   assign tls_done = tls_hit && (count_ff == TLS_HELD_LAST);
   assign plain_done = plain_hit && (count_ff == PLAIN_HELD_LAST);
   assign hold = (plain_hit || tls_hit) && !tls_done && !plain_done;
   assign mismatch = !(plain_hit || tls_hit);

   // Held bytes always match the prefix of a scheme that was still possible.
   assign held_char = plain_ff ? plain_char(idx_ff) : tls_char(idx_ff);
   assign replay_last = (idx_ff == count_ff);

   always_comb begin
      mode_in = mode_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      plain_in = plain_ff;
      tls_in = tls_ff;
      pend_byte_in = pend_byte_ff;
      pend_end_in = pend_end_ff;
      case (mode_ff)
         FRONT_PREFIX: begin
            if (accept) begin
               if (req.end_mark) begin
                  if (count_ff != '0) begin
                     mode_in = FRONT_REPLAY;
                     idx_in = '0;
                     pend_end_in = 1'b1;
                  end
               end else if (tls_done || plain_done) begin
                  mode_in = FRONT_PASS;
                  count_in = '0;
                  plain_in = 1'b1;
                  tls_in = 1'b1;
               end else if (hold) begin
                  count_in = count_ff + 1'b1;
                  plain_in = plain_hit;
                  tls_in = tls_hit;
               end else if (mismatch) begin
                  if (count_ff == '0) begin
                     mode_in = FRONT_PASS;
                  end else begin
                     mode_in = FRONT_REPLAY;
                     idx_in = '0;
                     pend_byte_in = req.char_byte;
                     pend_end_in = 1'b0;
                  end
               end
            end
         end
         FRONT_REPLAY: begin
            if (!queue_full) begin
               if (replay_last) begin
                  mode_in = pend_end_ff ? FRONT_PREFIX : FRONT_PASS;
                  count_in = '0;
                  plain_in = 1'b1;
                  tls_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         FRONT_PASS: begin
            if (accept && req.end_mark) begin
               mode_in = FRONT_PREFIX;
            end
         end
         default: begin
            mode_in = FRONT_PREFIX;
         end
      endcase
   end

   always_comb begin
      push_valid = 1'b0;
      push_cmd = '{kind: CMD_FEED, char_byte: req.char_byte};
      case (mode_ff)
         FRONT_PREFIX: begin
            if (accept) begin
               if (req.end_mark) begin
                  if (count_ff == '0) begin
                     push_valid = 1'b1;
                     push_cmd.kind = CMD_END;
                  end
               end else if (tls_done) begin
                  push_valid = 1'b1;
                  push_cmd.kind = CMD_REFUSE;
               end else if (mismatch && (count_ff == '0)) begin
                  push_valid = 1'b1;
               end
            end
         end
         FRONT_REPLAY: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               if (replay_last) begin
                  push_cmd.kind = pend_end_ff ? CMD_END : CMD_FEED;
                  push_cmd.char_byte = pend_byte_ff;
               end else begin
                  push_cmd.char_byte = held_char;
               end
            end
         end
         FRONT_PASS: begin
            if (accept) begin
               push_valid = 1'b1;
               push_cmd.kind = req.end_mark ? CMD_END : CMD_FEED;
            end
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= FRONT_PREFIX;
         count_ff <= '0;
         idx_ff <= '0;
         plain_ff <= 1'b1;
         tls_ff <= 1'b1;
         pend_end_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         plain_ff <= plain_in;
         tls_ff <= tls_in;
         pend_end_ff <= pend_end_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
   end

endmodule

FILE: sv/urlsp_back.sv
// Back end: splits fed characters into host, port and path and drives the response register.
// Depends on urlsp_pkg, the response interface and the assertion macros.
`include "http_url_splitter_macros.svh"

module urlsp_back import urlsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [HOST_CAP_W-1:0] host_cap,
   input  logic [PATH_CAP_W-1:0] path_cap,
   input  logic                  pop_valid,
   input  cmd_type               pop_cmd,
   output logic                  pop,
   urlsp_rsp_if.source rsp
);

   phase_type             phase_ff, phase_in;
   logic [HOST_CAP_W-1:0] host_count_ff, host_count_in;
   logic [PATH_CAP_W-1:0] path_count_ff, path_count_in;
   logic [15:0]           port_ff, port_in;
   logic [1:0]            error_ff, error_in;
   logic                  slash_ff, slash_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, outcome_ff;
   logic [7:0]  value_ff;
   logic [15:0] port_out_ff;
   logic        last_ff;

   logic                  advance, work, emit, fin_fire;
   logic [1:0]            e_kind, e_outcome;
   logic [7:0]            e_value;
   logic [15:0]           e_port;
   logic                  e_last;
   logic [HOST_CAP_W-1:0] host_lim;
   logic [PATH_CAP_W-1:0] path_lim;
   logic                  host_full, path_room, is_digit;
   logic [19:0]           port_wide;
   logic [15:0]           port_sat;
   logic [1:0]            error_end;
   logic [7:0]            ch;

   assign ch = pop_cmd.char_byte;
   assign advance = !rsp_valid_ff || rsp.ready;
   assign work = pop_valid && advance;

   assign host_lim = (host_cap == '0) ? '0 : host_cap - 1'b1;
   assign path_lim = (path_cap == '0) ? '0 : path_cap - 1'b1;
   assign host_full = (host_count_ff >= host_lim);
   assign path_room = (path_count_ff < path_lim);
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

   assign port_wide = ({4'b0, port_ff} << 3) + ({4'b0, port_ff} << 1) + {16'b0, ch[3:0]};
   assign port_sat = (port_wide > {4'b0, PORT_MAX}) ? PORT_MAX : port_wide[15:0];

   assign error_end = ((error_ff == OUTCOME_OK) && (phase_ff == PHASE_HOST) &&
                       (host_count_ff == '0)) ? OUTCOME_MALFORMED : error_ff;

   always_comb begin
      phase_in = phase_ff;
      host_count_in = host_count_ff;
      path_count_in = path_count_ff;
      port_in = port_ff;
      error_in = error_ff;
      slash_in = slash_ff;
      emit = 1'b0;
      e_kind = KIND_PATH;
      e_value = ch;
      e_outcome = OUTCOME_OK;
      e_port = '0;
      e_last = 1'b0;
      pop = 1'b0;
      fin_fire = 1'b0;
      if (work) begin
         case (pop_cmd.kind)
            CMD_FEED: begin
               pop = 1'b1;
               case (phase_ff)
                  PHASE_HOST: begin
                     if ((ch == CHAR_COLON) || (ch == CHAR_SLASH) || host_full) begin
                        if (host_count_ff == '0) begin
                           error_in = OUTCOME_MALFORMED;
                           phase_in = PHASE_DRAIN;
                        end else if (ch == CHAR_COLON) begin
                           phase_in = PHASE_PORT;
                        end else begin
                           phase_in = PHASE_PATH;
                           if (path_room) begin
                              emit = 1'b1;
                              path_count_in = path_count_ff + 1'b1;
                           end
                        end
                     end else begin
                        emit = 1'b1;
                        e_kind = KIND_HOST;
                        host_count_in = host_count_ff + 1'b1;
                     end
                  end
                  PHASE_PORT: begin
                     if (is_digit) begin
                        port_in = port_sat;
                     end else begin
                        phase_in = PHASE_PATH;
                        if (path_room) begin
                           emit = 1'b1;
                           path_count_in = path_count_ff + 1'b1;
                        end
                     end
                  end
                  PHASE_PATH: begin
                     if (path_room) begin
                        emit = 1'b1;
                        path_count_in = path_count_ff + 1'b1;
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
            CMD_REFUSE: begin
               pop = 1'b1;
               error_in = OUTCOME_TLS;
               phase_in = PHASE_DRAIN;
            end
            CMD_END: begin
               emit = 1'b1;
               e_value = '0;
               if ((error_end == OUTCOME_OK) && (phase_ff != PHASE_PATH) &&
                   (path_cap >= PATH_CAP_W'(2)) && !slash_ff) begin
                  // An empty path is reported as a single slash before the final item.
                  e_value = CHAR_SLASH;
                  slash_in = 1'b1;
               end else begin
                  pop = 1'b1;
                  fin_fire = 1'b1;
                  e_kind = KIND_FINAL;
                  e_last = 1'b1;
                  if (error_end == OUTCOME_TLS) begin
                     e_outcome = OUTCOME_TLS;
                  end else if (error_end != OUTCOME_OK) begin
                     e_outcome = OUTCOME_MALFORMED;
                     e_port = PORT_DEFAULT;
                  end else begin
                     e_port = (port_ff == '0) ? PORT_DEFAULT : port_ff;
                  end
                  phase_in = PHASE_HOST;
                  host_count_in = '0;
                  path_count_in = '0;
                  port_in = '0;
                  error_in = OUTCOME_OK;
                  slash_in = 1'b0;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HOST;
         host_count_ff <= '0;
         path_count_ff <= '0;
         port_ff <= '0;
         error_ff <= OUTCOME_OK;
         slash_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         host_count_ff <= host_count_in;
         path_count_ff <= path_count_in;
         port_ff <= port_in;
         error_ff <= error_in;
         slash_ff <= slash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         kind_ff <= e_kind;
         value_ff <= e_value;
         outcome_ff <= e_outcome;
         port_out_ff <= e_port;
         last_ff <= e_last;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.item_kind = kind_ff;
   assign rsp.value = value_ff;
   assign rsp.outcome = outcome_ff;
   assign rsp.port_number = port_out_ff;
   assign rsp.last = last_ff;

   `URLSP_ASSERT(a_final_clears, clock, reset, fin_fire |=> ((phase_ff == PHASE_HOST) && (host_count_ff == '0) && (port_ff == '0) && (error_ff == OUTCOME_OK) && !slash_ff), "URL state not cleared after the final item")
   `URLSP_ASSERT(a_drain_has_error, clock, reset, (phase_ff == PHASE_DRAIN) |-> (error_ff != OUTCOME_OK), "drain phase without an error code")
   `URLSP_ASSERT(a_port_phase, clock, reset, (port_ff != '0) |-> ((phase_ff == PHASE_PORT) || (phase_ff == PHASE_PATH)), "port value outside the port or path phase")

endmodule

FILE: sv/http_url_splitter.sv
// Top level of the URL splitter: register port, front end, command queue and back end.
// Depends on urlsp_pkg, the channel interfaces, urlsp_front, urlsp_fifo and urlsp_back.
//
//   Channel    Modport  Carries
//   req_chan   sink     char_byte, end_mark
//   rsp_chan   source   item_kind, value, outcome, port_number, last
//   csr_chan   sink     index, data (0 host capacity, 1 path capacity)
//
// One character is taken per cycle while the prefix is held or passed through and the queue is not full.
// An item that breaks a held prefix stalls the request side
// while the held bytes and that item are replayed into the queue.
// An end marker on a URL with an empty path yields two back-end items (slash, then final).
// The queue of QUEUE_DEPTH commands lets the request side run while the response stalls.
// Reset is synchronous and leaves the host capacity at 256 and the path capacity at 1024.
module http_url_splitter import urlsp_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   urlsp_req_if.sink   req_chan,
   urlsp_rsp_if.source rsp_chan,
   urlsp_csr_if.sink   csr_chan
);

   logic [HOST_CAP_W-1:0] host_cap_ff, host_cap_in;
   logic [PATH_CAP_W-1:0] path_cap_ff, path_cap_in;

   logic    push_valid, queue_full, pop, pop_valid;
   cmd_type push_cmd, pop_cmd;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      host_cap_in = host_cap_ff;
      path_cap_in = path_cap_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_HOST_CAP: host_cap_in = csr_chan.data[HOST_CAP_W-1:0];
            CSR_PATH_CAP: path_cap_in = csr_chan.data[PATH_CAP_W-1:0];
            default: begin
               host_cap_in = host_cap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_cap_ff <= HOST_CAP_RESET;
         path_cap_ff <= PATH_CAP_RESET;
      end else begin
         host_cap_ff <= host_cap_in;
         path_cap_ff <= path_cap_in;
      end
   end

   urlsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   urlsp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   urlsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .host_cap  (host_cap_ff),
      .path_cap  (path_cap_ff),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule
